// File: hdl/microcoded_alu_sequencer_step_top_assert.svh
// Assertion macros for the microcoded ALU sequencer step top level.
// Included by the top level; depends on nothing else.
`ifndef MICROCODED_ALU_SEQUENCER_STEP_TOP_ASSERT_SVH
`define MICROCODED_ALU_SEQUENCER_STEP_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MASQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MASQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/masq_pkg.sv
// Package for the microcoded ALU sequencer step: beat layouts, select codes
// and the 74181-style ALU functions. Depends on nothing.
`default_nettype none

package masq_pkg;

  localparam logic [2:0] REG_PCH = 3'd0;
  localparam logic [2:0] REG_PCL = 3'd1;
  localparam logic [2:0] REG_SPH = 3'd2;
  localparam logic [2:0] REG_SPL = 3'd3;
  localparam logic [2:0] REG_MARH = 3'd4;
  localparam logic [2:0] REG_MARL = 3'd5;
  localparam logic [2:0] REG_ACC = 3'd6;
  localparam logic [2:0] REG_SR = 3'd7;
  localparam int NUM_REGS = 8;

  localparam logic [3:0] BR_Z = 4'd0;
  localparam logic [3:0] BR_N = 4'd1;
  localparam logic [3:0] BR_C4 = 4'd2;
  localparam logic [3:0] BR_C8 = 4'd3;
  localparam logic [3:0] BR_MC = 4'd4;
  localparam logic [3:0] BR_NOT_Z = 4'd8;
  localparam logic [3:0] BR_NOT_N = 4'd9;
  localparam logic [3:0] BR_NOT_C4 = 4'd10;
  localparam logic [3:0] BR_NOT_C8 = 4'd11;
  localparam logic [3:0] BR_NOT_MC = 4'd12;
  localparam logic [3:0] BR_ALWAYS = 4'd13;

  localparam logic [1:0] ADDR_PC = 2'd0;
  localparam logic [1:0] ADDR_SP = 2'd1;
  localparam logic [1:0] ADDR_MAR = 2'd2;
  localparam logic [15:0] ADDR_ONES = 16'hffff;

  localparam logic [1:0] BSEL_CONST = 2'd1;
  localparam logic [1:0] BSEL_ONES = 2'd3;

  localparam logic [1:0] CIN_MICRO = 2'd0;
  localparam logic [1:0] CIN_SR3 = 2'd1;
  localparam logic [1:0] CIN_ONE = 2'd2;

  typedef enum logic [3:0] {
    AR_A, AR_A_OR_B, AR_A_OR_NB, AR_MINUS_ONE, AR_A_PLUS_A_NB, AR_OR_PLUS_A_NB,
    AR_A_MINUS_B, AR_A_NB_MINUS_ONE, AR_A_PLUS_AB, AR_A_PLUS_B, AR_ORNB_PLUS_AB,
    AR_AB_MINUS_ONE, AR_A_PLUS_A, AR_OR_PLUS_A, AR_ORNB_PLUS_A, AR_A_MINUS_ONE
  } alu_arith_t;

  typedef enum logic [3:0] {
    LG_NOT_A, LG_NOR, LG_NA_AND_B, LG_ZERO, LG_NAND, LG_NOT_B, LG_XOR, LG_A_AND_NB,
    LG_NA_OR_B, LG_XNOR, LG_B, LG_AND, LG_ONES, LG_A_OR_NB, LG_OR, LG_A
  } alu_logic_t;

  typedef struct packed {
    logic       pad;
    logic [2:0] register_index;
    logic       micro_carry;
    logic [7:0] data_in;
    logic [7:0] constant;
    logic [4:0] alu_function;
    logic       increment_pc;
    logic [1:0] carry_select;
    logic [2:0] a_select;
    logic [1:0] b_select;
    logic [1:0] address_select;
    logic [3:0] branch_select;
  } in_beat_t;

  typedef struct packed {
    logic        byte_carry_n;
    logic        nibble_carry_n;
    logic [7:0]  alu_result;
    logic [15:0] address_out;
    logic        branch_taken;
  } result_t;

  // Arithmetic half of the ALU, modulo 2^9; the complement of B covers all
  // nine bits so that carries match a wide two's complement computation.
  function automatic logic [8:0] alu_arith(input logic [3:0] fn, input logic [8:0] a,
                                           input logic [8:0] b, input logic c);
    logic [8:0] nb;
    logic [8:0] ci;
    logic [8:0] f;
    nb = ~b;
    ci = {8'd0, c};
    case (alu_arith_t'(fn))
      AR_A: f = a + 9'd1 - ci;
      AR_A_OR_B: f = (a | b) + 9'd1 - ci;
      AR_A_OR_NB: f = (a | nb) + 9'd1 - ci;
      AR_MINUS_ONE: f = 9'd0 - ci;
      AR_A_PLUS_A_NB: f = a + (a & nb) + 9'd1 - ci;
      AR_OR_PLUS_A_NB: f = (a | b) + (a & nb) + 9'd1 - ci;
      AR_A_MINUS_B: f = a - b - ci;
      AR_A_NB_MINUS_ONE: f = (a & nb) - ci;
      AR_A_PLUS_AB: f = a + (a & b) + 9'd1 - ci;
      AR_A_PLUS_B: f = a + b + 9'd1 - ci;
      AR_ORNB_PLUS_AB: f = (a | nb) + (a & b) + 9'd1 - ci;
      AR_AB_MINUS_ONE: f = (a & b) - ci;
      AR_A_PLUS_A: f = a + a + 9'd1 - ci;
      AR_OR_PLUS_A: f = (a | b) + a + 9'd1 - ci;
      AR_ORNB_PLUS_A: f = (a | nb) + a + 9'd1 - ci;
      default: f = a - ci;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] alu_logic(input logic [3:0] fn, input logic [7:0] a,
                                           input logic [7:0] b);
    logic [7:0] f;
    case (alu_logic_t'(fn))
      LG_NOT_A: f = ~a;
      LG_NOR: f = ~(a | b);
      LG_NA_AND_B: f = ~a & b;
      LG_NAND: f = ~(a & b);
      LG_NOT_B: f = ~b;
      LG_XOR: f = a ^ b;
      LG_A_AND_NB: f = a & ~b;
      LG_NA_OR_B: f = ~a | b;
      LG_XNOR: f = ~(a ^ b);
      LG_B: f = b;
      LG_AND: f = a & b;
      LG_ONES: f = 8'hff;
      LG_A_OR_NB: f = a | ~b;
      LG_OR: f = a | b;
      LG_A: f = a;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// File: hdl/microcoded_alu_sequencer_step_top.sv
// Top level of the microcoded ALU sequencer step: machine registers, branch
// condition, address mux, 74181-style ALU and a two-beat output buffer.
// Depends on masq_pkg and microcoded_alu_sequencer_step_top_assert.svh.
`default_nettype none

// Takes one beat per clock while s_tready is high and returns one result beat per
// input beat, in order, on the cycle after it is accepted at the earliest. A register write
// beat (s_tuser high) and a microword beat both complete at the accepting edge:
// the machine registers that they write update at that edge, so the next beat
// sees the new values. Two result beats can be held while m_tready is low;
// s_tready drops only once both are full. Reset clears all machine registers.
module microcoded_alu_sequencer_step_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // From bit 0: branch_select, address_select, b_select, a_select,
  // carry_select, increment_pc, alu_function, constant, data_in,
  // micro_carry, register_index, zero pad.
  input  wire logic [39:0] s_tdata,
  // Bit 0: op.
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // From bit 0: branch_taken, address_out, alu_result, nibble_carry_n,
  // byte_carry_n, zero pad.
  output logic [31:0]      m_tdata
);

`include "microcoded_alu_sequencer_step_top_assert.svh"

  masq_pkg::in_beat_t in_beat;
  masq_pkg::result_t  result;
  masq_pkg::result_t  out_data;
  masq_pkg::result_t  skid_data;
  logic               out_valid;
  logic               skid_valid;
  logic               accept;
  logic               take;
  logic [7:0]         regs [masq_pkg::NUM_REGS];
  logic [7:0]         sr;
  logic [7:0]         a_op;
  logic [7:0]         b_op;
  logic               cin;
  logic               taken;
  logic [15:0]        addr;
  logic [15:0]        pc_inc;
  logic [8:0]         full_sum;
  logic [8:0]         nib_sum;
  logic               is_sub;
  logic [7:0]         f;
  logic               c4;
  logic               c8;

  assign in_beat = masq_pkg::in_beat_t'(s_tdata);
  assign s_tready = !skid_valid;
  assign accept = s_tvalid && s_tready;
  assign take = m_tvalid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata = {5'd0, out_data};

  assign sr = regs[masq_pkg::REG_SR];
  assign a_op = regs[in_beat.a_select];
  assign pc_inc = {regs[masq_pkg::REG_PCH], regs[masq_pkg::REG_PCL]} + 16'd1;

  always_comb begin
    case (in_beat.branch_select)
      masq_pkg::BR_Z: taken = sr[0];
      masq_pkg::BR_N: taken = sr[1];
      masq_pkg::BR_C4: taken = sr[2];
      masq_pkg::BR_C8: taken = sr[3];
      masq_pkg::BR_MC: taken = in_beat.micro_carry;
      masq_pkg::BR_NOT_Z: taken = !sr[0];
      masq_pkg::BR_NOT_N: taken = !sr[1];
      masq_pkg::BR_NOT_C4: taken = !sr[2];
      masq_pkg::BR_NOT_C8: taken = !sr[3];
      masq_pkg::BR_NOT_MC: taken = !in_beat.micro_carry;
      masq_pkg::BR_ALWAYS: taken = 1'b1;
      default: taken = 1'b0;
    endcase

    case (in_beat.address_select)
      masq_pkg::ADDR_PC: addr = {regs[masq_pkg::REG_PCH], regs[masq_pkg::REG_PCL]};
      masq_pkg::ADDR_SP: addr = {regs[masq_pkg::REG_SPH], regs[masq_pkg::REG_SPL]};
      masq_pkg::ADDR_MAR: addr = {regs[masq_pkg::REG_MARH], regs[masq_pkg::REG_MARL]};
      default: addr = masq_pkg::ADDR_ONES;
    endcase

    case (in_beat.b_select)
      masq_pkg::BSEL_CONST: b_op = in_beat.constant;
      masq_pkg::BSEL_ONES: b_op = 8'hff;
      default: b_op = in_beat.data_in;
    endcase

    case (in_beat.carry_select)
      masq_pkg::CIN_MICRO: cin = in_beat.micro_carry;
      masq_pkg::CIN_SR3: cin = sr[3];
      masq_pkg::CIN_ONE: cin = 1'b1;
      default: cin = 1'b0;
    endcase

    full_sum = masq_pkg::alu_arith(in_beat.alu_function[3:0], {1'b0, a_op},
                                   {1'b0, b_op}, cin);
    nib_sum = masq_pkg::alu_arith(in_beat.alu_function[3:0], {5'd0, a_op[3:0]},
                                  {5'd0, b_op[3:0]}, cin);
    is_sub = (in_beat.alu_function[3:0] == masq_pkg::AR_A_MINUS_B) ||
             (in_beat.alu_function[3:0] == masq_pkg::AR_A_NB_MINUS_ONE) ||
             (in_beat.alu_function[3:0] == masq_pkg::AR_AB_MINUS_ONE) ||
             (in_beat.alu_function[3:0] == masq_pkg::AR_A_MINUS_ONE);

    if (in_beat.alu_function[4]) begin
      f = masq_pkg::alu_logic(in_beat.alu_function[3:0], a_op, b_op);
      c4 = 1'b1;
      c8 = 1'b1;
    end else begin
      f = full_sum[7:0];
      c4 = is_sub ? nib_sum[4] : !nib_sum[4];
      c8 = is_sub ? full_sum[8] : !full_sum[8];
    end

    if (s_tuser) begin
      result.branch_taken = 1'b0;
      result.address_out = 16'd0;
      result.alu_result = 8'd0;
      result.nibble_carry_n = 1'b1;
      result.byte_carry_n = 1'b1;
    end else begin
      result.branch_taken = taken;
      result.address_out = addr;
      result.alu_result = f;
      result.nibble_carry_n = c4;
      result.byte_carry_n = c8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < masq_pkg::NUM_REGS; i++) begin
        regs[i] <= 8'd0;
      end
    end else if (accept) begin
      if (s_tuser) begin
        regs[in_beat.register_index] <= in_beat.data_in;
      end else if (in_beat.increment_pc) begin
        regs[masq_pkg::REG_PCH] <= pc_inc[15:8];
        regs[masq_pkg::REG_PCL] <= pc_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data <= result;
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_data <= result;
      skid_valid <= 1'b1;
    end
  end

  `MASQ_ASSERT_NOW(a_skid_needs_out, clk, rst, skid_valid, out_valid,
                   "Skid beat held while output register is empty.")
  `MASQ_ASSERT_NEXT(a_reg_write, clk, rst, accept && s_tuser,
                    regs[$past(in_beat.register_index)] == $past(in_beat.data_in),
                    "Register write beat did not update the machine register.")
  `MASQ_ASSERT_NEXT(a_pc_increment, clk, rst, accept && !s_tuser && in_beat.increment_pc,
                    {regs[masq_pkg::REG_PCH], regs[masq_pkg::REG_PCL]} == $past(pc_inc),
                    "Program counter did not increment.")

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the microcoded ALU sequencer step: a built-in model predicts
// every result beat from the accepted input beats and compares field by field.
// Depends on masq_pkg and microcoded_alu_sequencer_step_top.

module tb_top;

  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam int TAIL_CYCLES = 8;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_PER_PHASE = 134;

  class alu_step_model_t;
    logic [7:0] regs [masq_pkg::NUM_REGS];
    masq_pkg::result_t expected_results [$];
    int n_writes, n_execs, n_taken, n_pc_incs, n_checked, n_errors;

    function new();
      foreach (regs[k]) regs[k] = 8'h00;
    endfunction

    function logic [31:0] arith_sum(logic [3:0] fn, logic [31:0] a, logic [31:0] b, logic c);
      logic [31:0] nb;
      logic [31:0] ci;
      nb = ~b;
      ci = {31'd0, c};
      case (masq_pkg::alu_arith_t'(fn))
        masq_pkg::AR_A:              return a + 32'd1 - ci;
        masq_pkg::AR_A_OR_B:         return (a | b) + 32'd1 - ci;
        masq_pkg::AR_A_OR_NB:        return (a | nb) + 32'd1 - ci;
        masq_pkg::AR_MINUS_ONE:      return 32'd0 - ci;
        masq_pkg::AR_A_PLUS_A_NB:    return a + (a & nb) + 32'd1 - ci;
        masq_pkg::AR_OR_PLUS_A_NB:   return (a | b) + (a & nb) + 32'd1 - ci;
        masq_pkg::AR_A_MINUS_B:      return a - b - ci;
        masq_pkg::AR_A_NB_MINUS_ONE: return (a & nb) - ci;
        masq_pkg::AR_A_PLUS_AB:      return a + (a & b) + 32'd1 - ci;
        masq_pkg::AR_A_PLUS_B:       return a + b + 32'd1 - ci;
        masq_pkg::AR_ORNB_PLUS_AB:   return (a | nb) + (a & b) + 32'd1 - ci;
        masq_pkg::AR_AB_MINUS_ONE:   return (a & b) - ci;
        masq_pkg::AR_A_PLUS_A:       return a + a + 32'd1 - ci;
        masq_pkg::AR_OR_PLUS_A:      return (a | b) + a + 32'd1 - ci;
        masq_pkg::AR_ORNB_PLUS_A:    return (a | nb) + a + 32'd1 - ci;
        default:                     return a - ci;
      endcase
    endfunction

    function logic [7:0] logic_out(logic [3:0] fn, logic [7:0] a, logic [7:0] b);
      case (masq_pkg::alu_logic_t'(fn))
        masq_pkg::LG_NOT_A:    return ~a;
        masq_pkg::LG_NOR:      return ~(a | b);
        masq_pkg::LG_NA_AND_B: return ~a & b;
        masq_pkg::LG_NAND:     return ~(a & b);
        masq_pkg::LG_NOT_B:    return ~b;
        masq_pkg::LG_XOR:      return a ^ b;
        masq_pkg::LG_A_AND_NB: return a & ~b;
        masq_pkg::LG_NA_OR_B:  return ~a | b;
        masq_pkg::LG_XNOR:     return ~(a ^ b);
        masq_pkg::LG_B:        return b;
        masq_pkg::LG_AND:      return a & b;
        masq_pkg::LG_ONES:     return 8'hff;
        masq_pkg::LG_A_OR_NB:  return a | ~b;
        masq_pkg::LG_OR:       return a | b;
        masq_pkg::LG_A:        return a;
        default:               return 8'h00;
      endcase
    endfunction

    function masq_pkg::result_t predict_step(logic op, masq_pkg::in_beat_t d);
      masq_pkg::result_t r;
      logic [7:0] sr;
      logic [7:0] a;
      logic [7:0] b;
      logic cin;
      logic sub;
      logic [15:0] pc;
      logic [31:0] wide;
      logic [31:0] nib;
      r = '0;
      r.nibble_carry_n = 1'b1;
      r.byte_carry_n = 1'b1;
      if (op == OP_WRITE) begin
        regs[d.register_index] = d.data_in;
        n_writes++;
        return r;
      end
      n_execs++;
      sr = regs[masq_pkg::REG_SR];
      case (d.branch_select)
        masq_pkg::BR_Z:      r.branch_taken = sr[0];
        masq_pkg::BR_N:      r.branch_taken = sr[1];
        masq_pkg::BR_C4:     r.branch_taken = sr[2];
        masq_pkg::BR_C8:     r.branch_taken = sr[3];
        masq_pkg::BR_MC:     r.branch_taken = d.micro_carry;
        masq_pkg::BR_NOT_Z:  r.branch_taken = ~sr[0];
        masq_pkg::BR_NOT_N:  r.branch_taken = ~sr[1];
        masq_pkg::BR_NOT_C4: r.branch_taken = ~sr[2];
        masq_pkg::BR_NOT_C8: r.branch_taken = ~sr[3];
        masq_pkg::BR_NOT_MC: r.branch_taken = ~d.micro_carry;
        masq_pkg::BR_ALWAYS: r.branch_taken = 1'b1;
        default:             r.branch_taken = 1'b0;
      endcase
      n_taken += r.branch_taken;
      pc = {regs[masq_pkg::REG_PCH], regs[masq_pkg::REG_PCL]};
      case (d.address_select)
        masq_pkg::ADDR_PC:  r.address_out = pc;
        masq_pkg::ADDR_SP:  r.address_out = {regs[masq_pkg::REG_SPH], regs[masq_pkg::REG_SPL]};
        masq_pkg::ADDR_MAR: r.address_out = {regs[masq_pkg::REG_MARH], regs[masq_pkg::REG_MARL]};
        default:            r.address_out = masq_pkg::ADDR_ONES;
      endcase
      case (d.b_select)
        masq_pkg::BSEL_CONST: b = d.constant;
        masq_pkg::BSEL_ONES:  b = 8'hff;
        default:              b = d.data_in;
      endcase
      a = regs[d.a_select];
      case (d.carry_select)
        masq_pkg::CIN_MICRO: cin = d.micro_carry;
        masq_pkg::CIN_SR3:   cin = sr[3];
        masq_pkg::CIN_ONE:   cin = 1'b1;
        default:             cin = 1'b0;
      endcase
      if (d.increment_pc) begin
        pc = pc + 16'd1;
        {regs[masq_pkg::REG_PCH], regs[masq_pkg::REG_PCL]} = pc;
        n_pc_incs++;
      end
      if (!d.alu_function[4]) begin
        wide = arith_sum(d.alu_function[3:0], {24'd0, a}, {24'd0, b}, cin);
        nib = arith_sum(d.alu_function[3:0], {28'd0, a[3:0]}, {28'd0, b[3:0]}, cin) & 32'h1f;
        sub = (d.alu_function[3:0] == masq_pkg::AR_A_MINUS_B) ||
              (d.alu_function[3:0] == masq_pkg::AR_A_NB_MINUS_ONE) ||
              (d.alu_function[3:0] == masq_pkg::AR_AB_MINUS_ONE) ||
              (d.alu_function[3:0] == masq_pkg::AR_A_MINUS_ONE);
        r.alu_result = wide[7:0];
        r.nibble_carry_n = sub ~^ (nib > 32'h0f);
        r.byte_carry_n = sub ~^ ((wide & 32'h1ff) > 32'hff);
      end else begin
        r.alu_result = logic_out(d.alu_function[3:0], a, b);
      end
      return r;
    endfunction

    function void note_beat(logic op, masq_pkg::in_beat_t d);
      expected_results.push_back(predict_step(op, d));
    endfunction

    function void cmp_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
      if (exp_val !== got_val) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
        n_errors++;
      end
    endfunction

    function void check_result(masq_pkg::result_t got);
      masq_pkg::result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        n_errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      n_checked++;
      cmp_field("branch_taken", exp_r.branch_taken, got.branch_taken);
      cmp_field("address_out", exp_r.address_out, got.address_out);
      cmp_field("alu_result", exp_r.alu_result, got.alu_result);
      cmp_field("nibble_carry_n", exp_r.nibble_carry_n, got.nibble_carry_n);
      cmp_field("byte_carry_n", exp_r.byte_carry_n, got.byte_carry_n);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;
  bit rx_hold_req = 1'b0;
  int cycles = 0;

  alu_step_model_t step_model = new();

  microcoded_alu_sequencer_step_top i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        step_model.check_result(masq_pkg::result_t'(m_tdata[$bits(masq_pkg::result_t)-1:0]));
      end
      if (s_tvalid && s_tready) begin
        step_model.note_beat(s_tuser, masq_pkg::in_beat_t'(s_tdata));
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Verification failed");
    $finish;
  end

  task automatic send_beat(input logic op, input masq_pkg::in_beat_t d);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    masq_pkg::in_beat_t d;
    d = '0;
    d.register_index = idx;
    d.data_in = value;
    send_beat(OP_WRITE, d);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (step_model.expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic rand_beat(output logic op, output masq_pkg::in_beat_t d);
    d = '0;
    op = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_EXEC;
    d.branch_select = 4'($urandom_range(0, 15));
    d.address_select = 2'($urandom_range(0, 3));
    d.b_select = 2'($urandom_range(0, 3));
    d.a_select = 3'($urandom_range(0, 7));
    d.carry_select = 2'($urandom_range(0, 3));
    d.increment_pc = 1'($urandom_range(0, 1));
    d.alu_function = 5'($urandom_range(0, 31));
    d.constant = pick_byte();
    d.data_in = pick_byte();
    d.micro_carry = 1'($urandom_range(0, 1));
    d.register_index = 3'($urandom_range(0, 7));
  endtask

  initial begin
    masq_pkg::in_beat_t d;
    logic op;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(masq_pkg::REG_PCH, 8'hff);
    write_reg(masq_pkg::REG_PCL, 8'hff);
    d = '0;
    d.address_select = masq_pkg::ADDR_PC;
    d.increment_pc = 1'b1;
    d.branch_select = masq_pkg::BR_ALWAYS;
    send_beat(OP_EXEC, d);
    write_reg(masq_pkg::REG_SPH, 8'h80);
    write_reg(masq_pkg::REG_SPL, 8'h01);
    write_reg(masq_pkg::REG_MARH, 8'h7f);
    write_reg(masq_pkg::REG_MARL, 8'hfe);
    write_reg(masq_pkg::REG_ACC, 8'h0f);
    write_reg(masq_pkg::REG_SR, 8'h05);
    for (int i = 0; i < 16; i++) begin
      d = '0;
      d.branch_select = i[3:0];
      d.address_select = i[1:0];
      d.b_select = i[3:2];
      d.a_select = i[2:0];
      d.carry_select = i[2:1];
      d.increment_pc = i[0];
      d.alu_function = {i[3:0], i[0]};
      d.constant = i[0] ? 8'hff : 8'h00;
      d.data_in = i[1] ? 8'h00 : 8'hff;
      d.micro_carry = i[2];
      d.register_index = i[2:0];
      send_beat(OP_EXEC, d);
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 60 : 0;
      rx_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 21 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 0 && n == 40) begin
          rx_hold_req = 1'b1;
        end
        rand_beat(op, d);
        send_beat(op, d);
      end
      drain();
    end

    if (step_model.expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               step_model.expected_results.size());
      step_model.n_errors++;
    end
    $display("Covered %0d register writes and %0d microwords (%0d branches taken, %0d PC steps)",
             step_model.n_writes, step_model.n_execs, step_model.n_taken, step_model.n_pc_incs);
    $display("Compared %0d result beats under three stall mixes, %0d mismatches",
             step_model.n_checked, step_model.n_errors);
    if (step_model.n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
